// File: design/sams_pkg.sv
`timescale 1ns / 1ps
// sams_pkg: op, command, mode and event codes and the result entry type
// for the stepper axis mode sequencer; no dependencies

package sams_pkg;

  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_SET_VEL  = 3'd1;
  localparam logic [2:0] OP_MOVE_TO  = 3'd2;
  localparam logic [2:0] OP_MOVE_BY  = 3'd3;
  localparam logic [2:0] OP_STOP     = 3'd4;
  localparam logic [2:0] OP_HOME     = 3'd5;
  localparam logic [2:0] OP_ENABLE   = 3'd6;

  localparam logic [2:0] CMD_NONE    = 3'd0;
  localparam logic [2:0] CMD_ENABLE  = 3'd1;
  localparam logic [2:0] CMD_ZERO    = 3'd2;
  localparam logic [2:0] CMD_STOP    = 3'd3;
  localparam logic [2:0] CMD_VEL     = 3'd4;
  localparam logic [2:0] CMD_MOVE    = 3'd5;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_VEL    = 2'd1;
  localparam logic [1:0] MODE_POS    = 2'd2;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_ARRIVED  = 2'd1;
  localparam logic [1:0] EV_TIMEOUT  = 2'd2;

  localparam logic [2:0] REG_INVERT  = 3'd0;
  localparam logic [2:0] REG_SPD_LIM = 3'd1;
  localparam logic [2:0] REG_CRUISE  = 3'd2;
  localparam logic [2:0] REG_ACCEL   = 3'd3;
  localparam logic [2:0] REG_TOL     = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;
  localparam logic [2:0] REG_POS_MIN = 3'd6;
  localparam logic [2:0] REG_POS_MAX = 3'd7;

  localparam int RES_SLOTS = 3;

  typedef struct packed {
    logic [2:0]  command;
    logic        direction;
    logic [14:0] speed_rpm;
    logic [7:0]  accel_code;
    logic [31:0] move_pulses;
    logic        enable_out;
    logic [1:0]  event_res;
    logic        last;
  } res_t;

endpackage

// File: design/stepper_axis_mode_sequencer.sv
`timescale 1ns / 1ps
// stepper_axis_mode_sequencer: top level, input register, tick pass, result buffer
// depends on sams_pkg
//
// Usage
//   in_*   : one beat per item (tick or command), valid/ready
//   out_*  : result beats of a tick, valid/ready, out_last on the final one
//   cfg_*  : register writes, always ready, write only while idle
// A beat is captured in the input register and processed from there.
// Commands update the axis state and give no result; a command never waits.
// A tick writes one to three results into a three-entry result buffer; the
// first result shows on out_* once the tick has moved from the input register
// into the buffer, and the rest follow one per cycle while out_ready is high.
// A tick waits in the input register until the buffer is empty or is handing
// over its last beat, so the buffer drain sets the tick rate.
// When the receiver stalls, the buffer holds; commands keep flowing until a
// tick waits in the input register.
// Reset clears the input register, the buffer and the axis state and loads
// the register defaults.

module stepper_axis_mode_sequencer
  import sams_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic signed [31:0] in_encoder_count,
  input  logic signed [15:0] in_speed_request,
  input  logic signed [31:0] in_position_request,
  input  logic               in_enable_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_command,
  output logic               out_direction,
  output logic [14:0]        out_speed_rpm,
  output logic [7:0]         out_accel_code,
  output logic [31:0]        out_move_pulses,
  output logic               out_enable_out,
  output logic [1:0]         out_event_res,
  output logic [1:0]         out_mode_now,
  output logic signed [31:0] out_position_now,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // configuration
  logic               cfg_invert_r;
  logic [14:0]        cfg_spd_lim_r;
  logic [14:0]        cfg_cruise_r;
  logic [7:0]         cfg_accel_r;
  logic [15:0]        cfg_tol_r;
  logic [15:0]        cfg_timeout_r;
  logic signed [31:0] cfg_pos_min_r;
  logic signed [31:0] cfg_pos_max_r;

  // input register
  logic               s1_valid_r;
  logic [2:0]         s1_op_r;
  logic signed [31:0] s1_enc_r;
  logic signed [15:0] s1_spd_r;
  logic signed [31:0] s1_preq_r;
  logic               s1_en_r;

  // axis state
  logic [1:0]         mode_r, mode_nxt;
  logic signed [15:0] tspd_r, tspd_nxt;
  logic signed [31:0] tpos_r, tpos_nxt;
  logic signed [31:0] cpos_r, cpos_nxt;
  logic               pend_r, pend_nxt;
  logic               home_r, home_nxt;
  logic               stop_r, stop_nxt;
  logic [1:0]         enreq_r, enreq_nxt;
  logic [15:0]        poll_r, poll_nxt;

  // result buffer
  res_t               res_r [RES_SLOTS];
  res_t               buf_nxt [RES_SLOTS];
  logic [1:0]         cnt_r, cnt_nxt;
  logic [1:0]         rd_r;
  logic [1:0]         mode_out_r;
  logic signed [31:0] pos_out_r;

  logic               out_fire;
  logic               buf_free;
  logic               is_tick;
  logic               fire;

  logic signed [31:0] cur_eff;
  logic signed [31:0] tgt_eff;
  logic [1:0]         mode_eff;
  logic signed [32:0] dist_raw;
  logic [32:0]        dist_mag;
  logic               dist_dir;
  logic [16:0]        spd_mag;
  logic [14:0]        spd_sat;
  logic               spd_dir;
  logic signed [32:0] rel_sum;
  logic signed [32:0] move_raw;
  logic signed [31:0] move_clamped;

  res_t               cand [4];
  logic [3:0]         cand_v;

  assign cfg_ready = 1'b1;

  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign is_tick   = (s1_op_r == OP_TICK);
  assign fire      = s1_valid_r && (!is_tick || buf_free);
  assign in_ready  = !s1_valid_r || fire;

  assign out_command      = res_r[rd_r].command;
  assign out_direction    = res_r[rd_r].direction;
  assign out_speed_rpm    = res_r[rd_r].speed_rpm;
  assign out_accel_code   = res_r[rd_r].accel_code;
  assign out_move_pulses  = res_r[rd_r].move_pulses;
  assign out_enable_out   = res_r[rd_r].enable_out;
  assign out_event_res    = res_r[rd_r].event_res;
  assign out_last         = res_r[rd_r].last;
  assign out_mode_now     = mode_out_r;
  assign out_position_now = pos_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_invert_r  <= 1'b0;
      cfg_spd_lim_r <= 15'd300;
      cfg_cruise_r  <= 15'd300;
      cfg_accel_r   <= 8'd0;
      cfg_tol_r     <= 16'd16;
      cfg_timeout_r <= 16'd100;
      cfg_pos_min_r <= 32'sd0;
      cfg_pos_max_r <= 32'sh7FFF_FFFF;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INVERT:  cfg_invert_r  <= cfg_data[0];
        REG_SPD_LIM: cfg_spd_lim_r <= cfg_data[14:0];
        REG_CRUISE:  cfg_cruise_r  <= cfg_data[14:0];
        REG_ACCEL:   cfg_accel_r   <= cfg_data[7:0];
        REG_TOL:     cfg_tol_r     <= cfg_data[15:0];
        REG_TIMEOUT: cfg_timeout_r <= cfg_data[15:0];
        REG_POS_MIN: cfg_pos_min_r <= cfg_data;
        REG_POS_MAX: cfg_pos_max_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // encoder sign is applied on capture, most negative count wraps to itself
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op_r   <= in_op;
      s1_enc_r  <= cfg_invert_r ? (32'sd0 - in_encoder_count) : in_encoder_count;
      s1_spd_r  <= in_speed_request;
      s1_preq_r <= in_position_request;
      s1_en_r   <= in_enable_value;
    end
  end

  // tick pass datapath
  always_comb begin
    cur_eff  = home_r ? 32'sd0 : s1_enc_r;
    tgt_eff  = home_r ? 32'sd0 : tpos_r;
    mode_eff = (home_r || stop_r) ? MODE_IDLE : mode_r;
    dist_raw = {tgt_eff[31], tgt_eff} - {cur_eff[31], cur_eff};
    dist_mag = dist_raw[32] ? (33'd0 - dist_raw) : dist_raw;
    dist_dir = cfg_invert_r ? (!dist_raw[32] && (dist_raw != 33'sd0)) : dist_raw[32];

    spd_mag  = tspd_r[15] ? (17'd0 - {tspd_r[15], tspd_r}) : {1'b0, tspd_r};
    spd_sat  = (spd_mag > {2'b00, cfg_spd_lim_r}) ? cfg_spd_lim_r : spd_mag[14:0];
    spd_dir  = cfg_invert_r ? (!tspd_r[15] && (tspd_r != 16'sd0)) : tspd_r[15];
  end

  // move target, relative moves are exact before the clamp
  always_comb begin
    rel_sum  = {s1_preq_r[31], s1_preq_r} + {cpos_r[31], cpos_r};
    move_raw = (s1_op_r == OP_MOVE_BY) ? rel_sum : {s1_preq_r[31], s1_preq_r};
    priority if (move_raw > $signed({cfg_pos_max_r[31], cfg_pos_max_r})) begin
      move_clamped = cfg_pos_max_r;
    end else if (move_raw < $signed({cfg_pos_min_r[31], cfg_pos_min_r})) begin
      move_clamped = cfg_pos_min_r;
    end else begin
      move_clamped = move_raw[31:0];
    end
  end

  always_comb begin
    logic [2:0] slot;
    logic [1:0] n;
    mode_nxt  = mode_r;
    tspd_nxt  = tspd_r;
    tpos_nxt  = tpos_r;
    cpos_nxt  = cpos_r;
    pend_nxt  = pend_r;
    home_nxt  = home_r;
    stop_nxt  = stop_r;
    enreq_nxt = enreq_r;
    poll_nxt  = poll_r;

    for (int i = 0; i < 4; i++) begin
      cand[i] = '0;
    end
    cand_v = '0;

    if (s1_valid_r) begin
      unique case (s1_op_r)
        OP_SET_VEL: begin
          tspd_nxt = s1_spd_r;
          stop_nxt = 1'b0;
          mode_nxt = MODE_VEL;
        end
        OP_MOVE_TO, OP_MOVE_BY: begin
          tpos_nxt = move_clamped;
          pend_nxt = 1'b1;
          stop_nxt = 1'b0;
          mode_nxt = MODE_POS;
        end
        OP_STOP:   stop_nxt  = 1'b1;
        OP_HOME:   home_nxt  = 1'b1;
        OP_ENABLE: enreq_nxt = {1'b1, s1_en_r};
        OP_TICK: begin
          cpos_nxt = cur_eff;
          tpos_nxt = tgt_eff;
          home_nxt = 1'b0;
          stop_nxt = 1'b0;
          mode_nxt = mode_eff;
          enreq_nxt = 2'b00;

          cand_v[0]          = home_r;
          cand[0].command    = CMD_ZERO;
          cand_v[1]          = enreq_r[1];
          cand[1].command    = CMD_ENABLE;
          cand[1].enable_out = enreq_r[0];
          cand_v[2]          = stop_r;
          cand[2].command    = CMD_STOP;

          unique case (mode_eff)
            MODE_VEL: begin
              cand_v[3]          = 1'b1;
              cand[3].command    = CMD_VEL;
              cand[3].direction  = spd_dir;
              cand[3].speed_rpm  = spd_sat;
            end
            MODE_POS: begin
              if (pend_r) begin
                pend_nxt  = 1'b0;
                cand_v[3] = 1'b1;
                if (dist_raw == 33'sd0) begin
                  mode_nxt          = MODE_IDLE;
                  cand[3].event_res = EV_ARRIVED;
                end else begin
                  poll_nxt            = 16'd0;
                  cand[3].command     = CMD_MOVE;
                  cand[3].direction   = dist_dir;
                  cand[3].speed_rpm   = cfg_cruise_r;
                  cand[3].accel_code  = cfg_accel_r;
                  cand[3].move_pulses = dist_mag[31:0];
                end
              end else if (dist_mag <= {17'd0, cfg_tol_r}) begin
                mode_nxt          = MODE_IDLE;
                cand_v[3]         = 1'b1;
                cand[3].event_res = EV_ARRIVED;
              end else if (poll_r >= cfg_timeout_r) begin
                mode_nxt          = MODE_IDLE;
                cand_v[3]         = 1'b1;
                cand[3].command   = CMD_STOP;
                cand[3].event_res = EV_TIMEOUT;
              end else begin
                poll_nxt = poll_r + 16'd1;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // pack the issued results into the first slots, at most three per tick
    for (int j = 0; j < RES_SLOTS; j++) begin
      buf_nxt[j] = '0;
    end
    slot = 3'd0;
    for (int i = 0; i < 4; i++) begin
      if (cand_v[i] && (slot < 3'(RES_SLOTS))) begin
        buf_nxt[slot[1:0]] = cand[i];
        slot = slot + 3'd1;
      end
    end
    // quiet tick still reports one beat
    n = (slot == 3'd0) ? 2'd1 : slot[1:0];
    for (int j = 0; j < RES_SLOTS; j++) begin
      buf_nxt[j].last = (2'(j) == (n - 2'd1));
    end
    cnt_nxt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      tspd_r  <= 16'sd0;
      tpos_r  <= 32'sd0;
      cpos_r  <= 32'sd0;
      pend_r  <= 1'b0;
      home_r  <= 1'b0;
      stop_r  <= 1'b0;
      enreq_r <= 2'b00;
      poll_r  <= 16'd0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      tspd_r  <= tspd_nxt;
      tpos_r  <= tpos_nxt;
      cpos_r  <= cpos_nxt;
      pend_r  <= pend_nxt;
      home_r  <= home_nxt;
      stop_r  <= stop_nxt;
      enreq_r <= enreq_nxt;
      poll_r  <= poll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 2'd0;
    end else if (fire && is_tick) begin
      cnt_r <= cnt_nxt;
      rd_r  <= 2'd0;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
      rd_r  <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_tick) begin
      for (int j = 0; j < RES_SLOTS; j++) begin
        res_r[j] <= buf_nxt[j];
      end
      mode_out_r <= mode_nxt;
      pos_out_r  <= cpos_nxt;
    end
  end

endmodule

// File: design/sams_checker.sv
`timescale 1ns / 1ps
// sams_checker: port-level assertions for the stepper axis mode sequencer,
// bound to the top level; depends on sams_pkg

module sams_checker
  import sams_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_command,
  input logic [14:0]        out_speed_rpm,
  input logic [31:0]        out_move_pulses,
  input logic [1:0]         out_mode_now,
  input logic signed [31:0] out_position_now,
  input logic               out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_command)
      && $stable(out_position_now) && $stable(out_last))
    else $error("result beat changed while stalled");

  // buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // the beats of one tick come back to back
  a_tick_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a tick's result beats");

  // mode and position are the same on every beat of a tick
  a_tick_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> $stable(out_mode_now)
      && $stable(out_position_now))
    else $error("tick report changed between beats");

  // beats without a motor command carry no motion
  a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_command == CMD_NONE) |-> (out_speed_rpm == 15'd0)
      && (out_move_pulses == 32'd0) && (out_mode_now != 2'd3))
    else $error("motion data on a beat without command");

endmodule

bind stepper_axis_mode_sequencer sams_checker u_sams_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_command      (out_command),
  .out_speed_rpm    (out_speed_rpm),
  .out_move_pulses  (out_move_pulses),
  .out_mode_now     (out_mode_now),
  .out_position_now (out_position_now),
  .out_last         (out_last)
);

// File: bench/tb_stepper_axis_mode_sequencer.sv
`timescale 1ns / 1ps
// tb_stepper_axis_mode_sequencer: self-checking bench for the stepper axis mode sequencer
// depends on sams_pkg and stepper_axis_mode_sequencer; predicts every result beat in-line

module tb_stepper_axis_mode_sequencer;
  import sams_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 10;
  localparam int MAX_PRINTS = 30;
  localparam longint POS_TOP = 64'sd2147483647;
  localparam longint POS_BOTTOM = -64'sd2147483648;

  typedef struct {
    logic [2:0]  command;
    logic        direction;
    logic [14:0] speed_rpm;
    logic [7:0]  accel_code;
    logic [31:0] move_pulses;
    logic        enable_out;
    logic [1:0]  event_res;
    logic [1:0]  mode_now;
    logic [31:0] position_now;
    logic        last;
  } motor_cmd_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         in_op = OP_TICK;
  logic signed [31:0] in_encoder_count = '0;
  logic signed [15:0] in_speed_request = '0;
  logic signed [31:0] in_position_request = '0;
  logic               in_enable_value = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_command;
  logic               out_direction;
  logic [14:0]        out_speed_rpm;
  logic [7:0]         out_accel_code;
  logic [31:0]        out_move_pulses;
  logic               out_enable_out;
  logic [1:0]         out_event_res;
  logic [1:0]         out_mode_now;
  logic signed [31:0] out_position_now;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = REG_INVERT;
  logic [31:0]        cfg_data = '0;

  stepper_axis_mode_sequencer uut (.*);

  // register mirror, reset values
  logic   cfg_invert = 1'b0;
  int     cfg_speed_limit = 300;
  int     cfg_cruise = 300;
  int     cfg_accel = 0;
  int     cfg_tol = 16;
  int     cfg_timeout = 100;
  longint cfg_pos_min = 0;
  longint cfg_pos_max = POS_TOP;

  // axis state mirror
  logic [1:0]         ax_mode = MODE_IDLE;
  logic signed [15:0] ax_speed = '0;
  longint             ax_target = 0;
  longint             ax_position = 0;
  logic               ax_move_pending = 1'b0;
  logic               ax_home_req = 1'b0;
  logic               ax_stop_req = 1'b0;
  logic               ax_en_pending = 1'b0;
  logic               ax_en_value = 1'b0;
  int                 ax_poll = 0;

  motor_cmd_t expected_cmds[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  int  reg_writes = 0;
  int  phases_run = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog: cycle limit reached with %0d beats outstanding", expected_cmds.size());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic dir_of(input longint v);
    if (cfg_invert) return v > 0;
    return v < 0;
  endfunction

  function automatic longint clamp_target(input longint t);
    if (t > cfg_pos_max) return cfg_pos_max;
    if (t < cfg_pos_min) return cfg_pos_min;
    return t;
  endfunction

  function automatic longint clamp32(input longint t);
    if (t > POS_TOP) return POS_TOP;
    if (t < POS_BOTTOM) return POS_BOTTOM;
    return t;
  endfunction

  function automatic motor_cmd_t make_cmd(input logic [2:0] cmd, input logic dir, input int spd,
                                          input int acc, input longint pulses, input logic en,
                                          input logic [1:0] ev);
    motor_cmd_t c;
    c.command = cmd;
    c.direction = dir;
    c.speed_rpm = 15'(spd);
    c.accel_code = 8'(acc);
    c.move_pulses = 32'(pulses);
    c.enable_out = en;
    c.event_res = ev;
    c.mode_now = MODE_IDLE;
    c.position_now = '0;
    c.last = 1'b0;
    return c;
  endfunction

  // updates the axis mirror for one accepted item and queues the beats a tick produces
  task automatic step_axis(input logic [2:0] op, input logic signed [31:0] enc,
                           input logic signed [15:0] spd, input logic signed [31:0] pos,
                           input logic en);
    longint e;
    longint d;
    longint mag;
    motor_cmd_t beats[$];
    case (op)
      OP_SET_VEL: begin
        ax_speed = spd;
        ax_stop_req = 1'b0;
        ax_mode = MODE_VEL;
      end
      OP_MOVE_TO, OP_MOVE_BY: begin
        e = pos;
        if (op == OP_MOVE_BY) e += ax_position;
        ax_target = clamp_target(e);
        ax_move_pending = 1'b1;
        ax_stop_req = 1'b0;
        ax_mode = MODE_POS;
      end
      OP_STOP: ax_stop_req = 1'b1;
      OP_HOME: ax_home_req = 1'b1;
      OP_ENABLE: begin
        ax_en_pending = 1'b1;
        ax_en_value = en;
      end
      OP_TICK: begin
        e = enc;
        if (cfg_invert) begin
          e = -e;
          // most negative count negates to itself
          if (e > POS_TOP) e -= 64'sd4294967296;
        end
        ax_position = e;
        if (ax_home_req) begin
          ax_home_req = 1'b0;
          ax_mode = MODE_IDLE;
          ax_position = 0;
          ax_target = 0;
          beats.push_back(make_cmd(CMD_ZERO, 1'b0, 0, 0, 0, 1'b0, EV_NONE));
        end
        if (ax_en_pending) begin
          ax_en_pending = 1'b0;
          beats.push_back(make_cmd(CMD_ENABLE, 1'b0, 0, 0, 0, ax_en_value, EV_NONE));
        end
        if (ax_stop_req) begin
          ax_stop_req = 1'b0;
          ax_mode = MODE_IDLE;
          beats.push_back(make_cmd(CMD_STOP, 1'b0, 0, 0, 0, 1'b0, EV_NONE));
        end
        if (ax_mode == MODE_VEL) begin
          e = ax_speed;
          mag = (e < 0) ? -e : e;
          if (mag > cfg_speed_limit) mag = cfg_speed_limit;
          beats.push_back(make_cmd(CMD_VEL, dir_of(e), int'(mag), 0, 0, 1'b0, EV_NONE));
        end else if (ax_mode == MODE_POS) begin
          d = ax_target - ax_position;
          mag = (d < 0) ? -d : d;
          if (ax_move_pending) begin
            ax_move_pending = 1'b0;
            if (d == 0) begin
              ax_mode = MODE_IDLE;
              beats.push_back(make_cmd(CMD_NONE, 1'b0, 0, 0, 0, 1'b0, EV_ARRIVED));
            end else begin
              beats.push_back(make_cmd(CMD_MOVE, dir_of(d), cfg_cruise, cfg_accel, mag, 1'b0,
                                       EV_NONE));
              ax_poll = 0;
            end
          end else if (mag <= cfg_tol) begin
            ax_mode = MODE_IDLE;
            beats.push_back(make_cmd(CMD_NONE, 1'b0, 0, 0, 0, 1'b0, EV_ARRIVED));
          end else if (ax_poll >= cfg_timeout) begin
            ax_mode = MODE_IDLE;
            beats.push_back(make_cmd(CMD_STOP, 1'b0, 0, 0, 0, 1'b0, EV_TIMEOUT));
          end else begin
            ax_poll = (ax_poll + 1) & 16'hFFFF;
          end
        end
        // a quiet tick still reports mode and position
        if (beats.size() == 0) beats.push_back(make_cmd(CMD_NONE, 1'b0, 0, 0, 0, 1'b0, EV_NONE));
        foreach (beats[k]) begin
          beats[k].mode_now = ax_mode;
          beats[k].position_now = 32'(ax_position);
          beats[k].last = (k == beats.size() - 1);
          expected_cmds.push_back(beats[k]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_seen, name, got, want));
  endtask

  // result side: compare each beat with the oldest expectation, stall in bursts
  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = expected_cmds.pop_front();
        check_field("command", out_command, want.command);
        check_field("direction", out_direction, want.direction);
        check_field("speed_rpm", out_speed_rpm, want.speed_rpm);
        check_field("accel_code", out_accel_code, want.accel_code);
        check_field("move_pulses", out_move_pulses, want.move_pulses);
        check_field("enable_out", out_enable_out, want.enable_out);
        check_field("event_res", out_event_res, want.event_res);
        check_field("mode_now", out_mode_now, want.mode_now);
        check_field("position_now", out_position_now, want.position_now);
        check_field("last", out_last, want.last);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rst_n && rx_gaps && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic signed [31:0] enc,
                           input logic signed [15:0] spd, input logic signed [31:0] pos,
                           input logic en);
    int gap;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_encoder_count <= enc;
    in_speed_request <= spd;
    in_position_request <= pos;
    in_enable_value <= en;
    do @(posedge clk); while (!in_ready);
    step_axis(op, enc, spd, pos, en);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // tick at an effective position, unused fields random
  task automatic do_tick(input longint p);
    logic signed [31:0] enc;
    enc = 32'(cfg_invert ? -p : p);
    send_item(OP_TICK, enc, 16'($urandom), $urandom, 1'($urandom));
  endtask

  task automatic do_cmd(input logic [2:0] op, input logic signed [15:0] spd,
                        input logic signed [31:0] pos, input logic en);
    send_item(op, $urandom, spd, pos, en);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INVERT:  cfg_invert = data[0];
      REG_SPD_LIM: cfg_speed_limit = data[14:0];
      REG_CRUISE:  cfg_cruise = data[14:0];
      REG_ACCEL:   cfg_accel = data[7:0];
      REG_TOL:     cfg_tol = data[15:0];
      REG_TIMEOUT: cfg_timeout = data[15:0];
      REG_POS_MIN: cfg_pos_min = $signed(data);
      REG_POS_MAX: cfg_pos_max = $signed(data);
      default: ;
    endcase
    reg_writes++;
  endtask

  // registers change only with the block idle: results drained, then a settling pause
  task automatic load_settings(input logic inv, input int lim, input int cruise, input int acc,
                               input int tol, input int tmo, input longint pmin,
                               input longint pmax);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_INVERT, {31'd0, inv});
    write_reg(REG_SPD_LIM, 32'(lim));
    write_reg(REG_CRUISE, 32'(cruise));
    write_reg(REG_ACCEL, 32'(acc));
    write_reg(REG_TOL, 32'(tol));
    write_reg(REG_TIMEOUT, 32'(tmo));
    write_reg(REG_POS_MIN, 32'(pmin));
    write_reg(REG_POS_MAX, 32'(pmax));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint rand_off(input int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint near_target();
    longint off;
    if ($urandom_range(0, 1)) off = $urandom_range(0, cfg_tol);
    else off = longint'(cfg_tol) + 1 + $urandom_range(0, 300);
    if ($urandom_range(0, 1)) off = -off;
    return clamp32(ax_target + off);
  endfunction

  function automatic int pick_speed();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 32767;
      2: return $urandom_range(0, 32767);
      default: return $urandom_range(100, 2000);
    endcase
  endfunction

  // mostly well-formed command/tick sequences, some noise
  task automatic run_random_phase(input int n_items);
    int stop_at;
    int n;
    longint req;
    stop_at = items_sent + n_items;
    phases_run++;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 7) == 0) req = $signed($urandom);
            else if ($urandom_range(0, 7) == 0) req = ax_position;
            else req = clamp32(ax_position + rand_off(4000));
            do_cmd(OP_MOVE_TO, 16'($urandom), 32'(req), 1'($urandom));
          end else begin
            if ($urandom_range(0, 7) == 0) req = $signed($urandom);
            else if ($urandom_range(0, 7) == 0) req = 0;
            else req = rand_off(4000);
            do_cmd(OP_MOVE_BY, 16'($urandom), 32'(req), 1'($urandom));
          end
          if ($urandom_range(0, 5) == 0) do_cmd(OP_SET_VEL, 16'(rand_off(500)), $urandom, 1'b0);
          if ($urandom_range(0, 7) == 0) do_cmd(OP_STOP, $urandom, $urandom, 1'($urandom));
          n = $urandom_range(1, 5);
          repeat (n) do_tick(near_target());
        end
        4, 5: begin
          if ($urandom_range(0, 3) == 0) do_cmd(OP_SET_VEL, 16'($urandom), $urandom, 1'b0);
          else do_cmd(OP_SET_VEL, 16'(rand_off(600)), $urandom, 1'b0);
          n = $urandom_range(1, 3);
          repeat (n) do_tick(clamp32(ax_position + rand_off(2000)));
          if ($urandom_range(0, 2) == 0) begin
            do_cmd(OP_STOP, $urandom, $urandom, 1'($urandom));
            do_tick(clamp32(ax_position + rand_off(50)));
          end
        end
        6: begin
          do_cmd(OP_HOME, $urandom, $urandom, 1'($urandom));
          if ($urandom_range(0, 1)) do_cmd(OP_ENABLE, $urandom, $urandom, 1'($urandom));
          if ($urandom_range(0, 1)) do_cmd(OP_STOP, $urandom, $urandom, 1'($urandom));
          do_tick(rand_off(3000));
        end
        7: begin
          do_cmd(OP_ENABLE, $urandom, $urandom, 1'($urandom));
          do_tick(clamp32(ax_position + rand_off(100)));
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(3'($urandom), $urandom, 16'($urandom), $urandom, 1'($urandom));
        end
      endcase
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  task automatic test_quiet_and_enable();
    do_tick(0);
    send_item(OP_UNUSED, 32'sh7FFF_FFFF, 16'sh7FFF, -32'sd1, 1'b1);
    send_item(OP_TICK, 32'sh8000_0000, 16'sh8000, 32'sh7FFF_FFFF, 1'b0);
    do_cmd(OP_ENABLE, 16'sd0, 32'sd0, 1'b1);
    do_tick(12345);
  endtask

  task automatic test_velocity();
    do_cmd(OP_SET_VEL, 16'sh8000, 32'sd0, 1'b0);
    send_item(OP_TICK, 32'sh7FFF_FFFF, 16'sd0, 32'sd0, 1'b0);
    // home, enable and stop together fill all three result slots
    do_cmd(OP_SET_VEL, 16'sh7FFF, 32'sd0, 1'b0);
    do_cmd(OP_STOP, 16'sd0, 32'sd0, 1'b0);
    do_cmd(OP_HOME, 16'sd0, 32'sd0, 1'b0);
    do_cmd(OP_ENABLE, 16'sd0, 32'sd0, 1'b0);
    do_tick(-77);
    do_cmd(OP_SET_VEL, 16'sd0, 32'sd0, 1'b0);
    do_tick(0);
  endtask

  task automatic test_position_moves();
    // below the lower limit clamps to zero, which is where the axis stands
    do_cmd(OP_MOVE_TO, 16'sd0, -32'sd100, 1'b0);
    do_tick(0);
    do_cmd(OP_MOVE_TO, 16'sd0, 32'sh7FFF_FFFF, 1'b0);
    do_tick(0);
    do_tick(POS_TOP - 16);
  endtask

  task automatic test_inverted_wiring();
    load_settings(1'b1, 300, 300, 7, 16, 0, -1000, 1000);
    do_cmd(OP_MOVE_BY, 16'sd0, 32'sd5000, 1'b0);
    do_tick(0);
    do_tick(0);
    do_cmd(OP_MOVE_TO, 16'sd0, -32'sd5000, 1'b0);
    do_tick(0);
    do_cmd(OP_SET_VEL, 16'sd250, 32'sd0, 1'b0);
    send_item(OP_TICK, 32'sh8000_0000, 16'sd0, 32'sd0, 1'b0);
  endtask

  task automatic test_extreme_settings();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    load_settings(1'b1, 32767, 32767, 255, 0, 65535, POS_BOTTOM, POS_TOP);
    run_random_phase(35);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_settings(1'b0, 0, 0, 0, 65535, 1, 0, 0);
    run_random_phase(25);
  endtask

  task automatic test_random_settings();
    longint lo;
    longint hi;
    repeat (3) begin
      tx_gaps = $urandom_range(0, 3) != 0;
      rx_gaps = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 2))
        0: begin
          lo = POS_BOTTOM;
          hi = POS_TOP;
        end
        1: begin
          lo = -longint'($urandom_range(0, 20000));
          hi = $urandom_range(0, 20000);
        end
        default: begin
          lo = $signed($urandom);
          hi = $signed($urandom);
        end
      endcase
      load_settings(1'($urandom), pick_speed(), pick_speed(), $urandom_range(0, 255),
                    ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 60),
                    $urandom_range(1, 6), lo, hi);
      run_random_phase(35);
    end
  endtask

  task automatic test_back_to_back();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_settings(1'($urandom), $urandom_range(50, 3000), $urandom_range(50, 3000),
                  $urandom_range(0, 255), $urandom_range(0, 40), $urandom_range(1, 4),
                  -longint'($urandom_range(0, 50000)), $urandom_range(0, 50000));
    run_random_phase(35);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_and_enable();
    test_velocity();
    test_position_moves();
    test_inverted_wiring();
    test_extreme_settings();
    test_random_settings();
    test_back_to_back();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d items and %0d result beats across %0d random phases",
             items_sent, beats_seen, phases_run);
    $display("with %0d register writes; %0d mismatches", reg_writes, err_count);
    if (err_count == 0 && expected_cmds.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
